FILE: hdl/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: hdl/dlt645_pkg.sv
package dlt645_pkg;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NO_START = 3'd1,
		ST_BAD_LEN  = 3'd2,
		ST_BAD_SUM  = 3'd3,
		ST_BAD_END  = 3'd4,
		ST_BAD_ID   = 3'd5
	} status_t;

	localparam logic [1:0] Q_ENERGY  = 2'd0;
	localparam logic [1:0] Q_VOLTAGE = 2'd1;
	localparam logic [1:0] Q_CURRENT = 2'd2;

	localparam logic [7:0] START_BYTE  = 8'h68;
	localparam logic [7:0] END_BYTE    = 8'h16;
	localparam logic [7:0] OFFSET_BYTE = 8'h33;
	localparam logic [7:0] TOP_MASK    = 8'h7F;

	localparam logic [7:0] ID_ENERGY_LO  = 8'h10;
	localparam logic [7:0] ID_ENERGY_HI  = 8'h90;
	localparam logic [7:0] ID_VOLTAGE_LO = 8'h91;
	localparam logic [7:0] ID_VOLTAGE_HI = 8'hB6;
	localparam logic [7:0] ID_CURRENT_LO = 8'hA1;
	localparam logic [7:0] ID_CURRENT_HI = 8'hB6;

	localparam logic [6:0] LEN_VOLTAGE = 7'd17;
	localparam logic [6:0] LEN_OTHER   = 7'd18;
	localparam logic [6:0] START_WINDOW = 7'd5;
	localparam logic [6:0] REL_IDENT   = 7'd10;
	localparam logic [6:0] REL_DATA    = 7'd12;

	localparam logic [27:0] MUL_1E6 = 28'd1000000;
	localparam logic [27:0] MUL_1E5 = 28'd100000;
	localparam logic [27:0] MUL_1E4 = 28'd10000;
	localparam logic [27:0] MUL_1E3 = 28'd1000;
	localparam logic [27:0] MUL_1E2 = 28'd100;
	localparam logic [27:0] MUL_1E1 = 28'd10;

	localparam logic [2:0] ADDR_QTY = 3'd0;

	// high nibble times ten plus low nibble, any nibble values
	function automatic logic [7:0] bcd_byte(input logic [7:0] b);
		bcd_byte = {4'd0, b[7:4]} * 8'd10 + {4'd0, b[3:0]};
	endfunction

endpackage

FILE: hdl/dlt645_1997_reply_checker.sv
// meter reply frame checker
// s_axis: one received reply byte per request in s_tdata, s_tlast on the last
//   byte of the frame. m_axis: one result per frame, status and decoded reading.
// apb: register 0 at address 0 selects the quantity (energy, voltage, current).
// a byte is registered on acceptance in the input register, from which the
// frame state and all frame checks are updated; the checks of a last byte go
// into the check result register, and the reading is assembled from it into
// the output register, which drives m_tvalid. one byte is taken every cycle,
// also while a result waits in the output register; bytes that are not last
// never wait. when m_tready stays low the results fill the output register
// and the internal result stage, and then s_tready drops on the next last byte.
// reset clears the frame state, empties the pipeline and sets the quantity to
// energy. after each frame end the frame state starts over.
module dlt645_1997_reply_checker #(
	parameter int MAX_FRAME_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tlast,   // frame_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [2:0] status, [30:3] reading, [31] zero
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import dlt645_pkg::*;
	`include "assert_macros.svh"

	localparam int PosCapInt = (MAX_FRAME_BYTES < 127) ? MAX_FRAME_BYTES : 127;
	localparam logic [6:0] POS_CAP = 7'(PosCapInt);

	logic [1:0] qty_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	logic [6:0] pos_q;
	logic [2:0] off_q;
	logic       start_found_q;
	logic [7:0] sum_q;
	logic [7:0] recent_q;
	logic [7:0] ident_q [2];
	logic [7:0] data_q  [4];

	logic       valid_s2;
	status_t    status_s2;
	logic [1:0] qty_s2;
	logic [7:0] d_s2 [4];

	logic        out_valid_q;
	logic [2:0]  out_status_q;
	logic [27:0] out_reading_q;

	logic out_free, s2_go, s2_free, s1_go;

	logic       ovf, found_now, sf_n, take;
	logic [2:0] off_n;
	logic [6:0] rel, pos_n, need, span;
	logic [7:0] sum_n, body;
	logic [7:0] ident_n [2];
	logic [7:0] data_n  [4];
	logic [7:0] i0, i1;
	status_t    status_n;

	logic [7:0]  b0, b1, b2, b3;
	logic [27:0] reading_n;

	// configuration
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_QTY) ? {30'd0, qty_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qty_q <= Q_ENERGY;
		end else if (psel && penable && pwrite && pready && paddr[2] == ADDR_QTY[2]) begin
			qty_q <= pwdata[1:0];
		end
	end

	// flow control
	assign out_free = !out_valid_q || m_tready;
	assign s2_go    = valid_s2 && out_free;
	assign s2_free  = !valid_s2 || s2_go;
	assign s1_go    = valid_s1 && (!last_s1 || s2_free);
	assign s_tready = !valid_s1 || s1_go;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// frame state update and checks
	always_comb begin
		ovf       = pos_q >= POS_CAP;
		found_now = !ovf && !start_found_q && pos_q < START_WINDOW && byte_s1 == START_BYTE;
		sf_n      = start_found_q || found_now;
		off_n     = found_now ? pos_q[2:0] : off_q;
		rel       = pos_q - {4'd0, off_n};
		take      = !ovf && sf_n;
		sum_n     = take ? sum_q + byte_s1 : sum_q;
		pos_n     = ovf ? pos_q : pos_q + 7'd1;
		ident_n   = ident_q;
		data_n    = data_q;
		if (take) begin
			if (rel == REL_IDENT || rel == REL_IDENT + 7'd1) begin
				ident_n[rel[0]] = byte_s1;
			end else if (rel >= REL_DATA && rel <= REL_DATA + 7'd3) begin
				data_n[rel[1:0]] = byte_s1;
			end
		end
		need = (qty_q == Q_VOLTAGE) ? LEN_VOLTAGE : LEN_OTHER;
		span = pos_n - {4'd0, off_n};
		body = sum_n - recent_q - byte_s1;
		i0   = ident_n[0] - OFFSET_BYTE;
		i1   = ident_n[1] - OFFSET_BYTE;
		if (ovf || pos_n < need) begin
			status_n = ST_BAD_LEN;
		end else if (!sf_n) begin
			status_n = ST_NO_START;
		end else if (span != need) begin
			status_n = ST_BAD_LEN;
		end else if (body != recent_q) begin
			status_n = ST_BAD_SUM;
		end else if (byte_s1 != END_BYTE) begin
			status_n = ST_BAD_END;
		end else if ((qty_q == Q_ENERGY && i0 == ID_ENERGY_LO && i1 == ID_ENERGY_HI) ||
			(qty_q == Q_VOLTAGE && i0 == ID_VOLTAGE_LO && i1 == ID_VOLTAGE_HI) ||
			(qty_q == Q_CURRENT && i0 == ID_CURRENT_LO && i1 == ID_CURRENT_HI)) begin
			status_n = ST_OK;
		end else begin
			status_n = ST_BAD_ID;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			off_q         <= '0;
			start_found_q <= 1'b0;
			sum_q         <= '0;
			recent_q      <= '0;
			ident_q       <= '{default: '0};
			data_q        <= '{default: '0};
		end else if (s1_go) begin
			if (last_s1) begin
				pos_q         <= '0;
				off_q         <= '0;
				start_found_q <= 1'b0;
				sum_q         <= '0;
				recent_q      <= '0;
				ident_q       <= '{default: '0};
				data_q        <= '{default: '0};
			end else begin
				pos_q         <= pos_n;
				off_q         <= off_n;
				start_found_q <= sf_n;
				sum_q         <= sum_n;
				recent_q      <= byte_s1;
				ident_q       <= ident_n;
				data_q        <= data_n;
			end
		end
	end

	// check result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_go && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			status_s2 <= status_n;
			qty_s2    <= qty_q;
			for (int i = 0; i < 4; i++) begin
				d_s2[i] <= data_n[i] - OFFSET_BYTE;
			end
		end
	end

	// reading assembly
	always_comb begin
		b0 = bcd_byte(d_s2[0]);
		b1 = bcd_byte(d_s2[1]);
		b2 = bcd_byte((qty_s2 == Q_VOLTAGE) ? (d_s2[2] & TOP_MASK) : d_s2[2]);
		b3 = bcd_byte((qty_s2 == Q_CURRENT) ? (d_s2[3] & TOP_MASK) : d_s2[3]);
		reading_n = '0;
		if (status_s2 == ST_OK) begin
			case (qty_s2)
				Q_ENERGY: begin
					reading_n = 28'(b3) * MUL_1E6 + 28'(b2) * MUL_1E4 +
						28'(b1) * MUL_1E2 + 28'(b0);
				end
				Q_VOLTAGE: begin
					reading_n = 28'(b2) * MUL_1E4 + 28'(b1) * MUL_1E2 + 28'(b0);
				end
				Q_CURRENT: begin
					// low byte divided by ten is its high nibble plus a carry of the low
					reading_n = 28'(b3) * MUL_1E5 + 28'(b2) * MUL_1E3 +
						28'(b1) * MUL_1E1 + 28'(d_s2[0][7:4]) +
						28'(d_s2[0][3:0] >= 4'd10);
				end
				default: begin
					reading_n = '0;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go) begin
			out_status_q  <= status_s2;
			out_reading_q <= reading_n;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_reading_q, out_status_q};

	`ASSERT_ALWAYS(a_off_window, !start_found_q || off_q < 3'd5, "start offset outside window")
	`ASSERT_ALWAYS(a_pos_cap, pos_q <= POS_CAP, "byte position above cap")
	`ASSERT_NEXT(a_clear, s1_go && last_s1, pos_q == 7'd0 && !start_found_q && sum_q == 8'd0, "frame state not cleared after frame end")
	`ASSERT_IMPLY(a_zero_reading, m_tvalid && m_tdata[2:0] != ST_OK, m_tdata[30:3] == 28'd0, "reading not zero on error status")
	`ASSERT_NEXT(a_result_taken, s1_go && last_s1, valid_s2, "frame end lost")

endmodule
